// ===== src/cedf_pkg.sv =====
package cedf_pkg;

    localparam int SAMPLE_BITS_DEF = 14;
    localparam int DEPTH_MIN       = 8;
    localparam int DEPTH_CAP       = 14;
    localparam int QP_W            = 6;
    localparam int QP_MAX          = 51;
    localparam int TH_W            = 14;   // 255 << 6 still fits
    localparam int TC_W            = 12;   // 25 << 6, plus one
    localparam int OFS_W           = 5;
    localparam int DEPTH_W         = 4;
    localparam int MODE_W          = 2;
    localparam int BS_W            = 3;
    localparam int CFG_DATA_W      = 5;

    localparam logic [BS_W-1:0] BS_NONE   = 3'd0;
    localparam logic [BS_W-1:0] BS_ONE    = 3'd1;
    localparam logic [BS_W-1:0] BS_TWO    = 3'd2;
    localparam logic [BS_W-1:0] BS_STRONG = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FILTER_ALL = 2'd0;

    typedef enum logic [1:0] {
        CFG_ALPHA_OFFSET = 2'd0,
        CFG_BETA_OFFSET  = 2'd1,
        CFG_BIT_DEPTH    = 2'd2,
        CFG_DISABLE_MODE = 2'd3
    } cfg_idx_t;

    localparam logic [7:0] ALPHA_TAB [0:51] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 8'd4, 8'd5, 8'd6,
        8'd7, 8'd8, 8'd9, 8'd10, 8'd12, 8'd13, 8'd15, 8'd17, 8'd20, 8'd22,
        8'd25, 8'd28, 8'd32, 8'd36, 8'd40, 8'd45, 8'd50, 8'd56, 8'd63, 8'd71,
        8'd80, 8'd90, 8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182, 8'd203, 8'd226,
        8'd255, 8'd255
    };

    localparam logic [7:0] BETA_TAB [0:51] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd2, 8'd2, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd6, 8'd6, 8'd7, 8'd7,
        8'd8, 8'd8, 8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd12,
        8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd17,
        8'd18, 8'd18
    };

    localparam logic [7:0] TC0_BS1 [0:51] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3,
        8'd4, 8'd4, 8'd4, 8'd5, 8'd6, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
        8'd11, 8'd13
    };

    localparam logic [7:0] TC0_BS2 [0:51] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4,
        8'd5, 8'd5, 8'd6, 8'd7, 8'd8, 8'd8, 8'd10, 8'd11, 8'd12, 8'd13,
        8'd15, 8'd17
    };

    localparam logic [7:0] TC0_BS3 [0:51] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2,
        8'd2, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd5, 8'd6, 8'd6,
        8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd13, 8'd14, 8'd16, 8'd18, 8'd20,
        8'd23, 8'd25
    };

endpackage

// ===== src/chroma_edge_deblock_filter.sv =====
// Chroma edge deblocking filter, one sample row (p1 p0 | q0 q1) per word.
// Input: pulse start with the row, strength and both QPs; the word is taken
// on any clock edge where start is high and busy is low. busy stays low, so
// a new row can be issued every cycle.
// Output: done is high for exactly one cycle with p0_result, q0_result and
// was_filtered. The receiver cannot hold results off; every word shows up
// once, in issue order.
// Pipeline: done rises once the row has passed the input stage, table
// lookup, activity test and delta, and clamp and output register. Throughput is
// one row per cycle; the four register stages each carry a valid bit.
// Config: cfg_valid/cfg_ready with cfg_index (0 alpha offset, 1 beta offset,
// 2 bit depth, 3 disable mode) and cfg_data. cfg_ready is always high. Write
// only while no rows are in flight.
// Reset (rst_n low, async): pipeline valids clear, offsets and mode go to 0,
// bit depth to 8.
module chroma_edge_deblock_filter #(
    parameter int SAMPLE_BITS = cedf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [SAMPLE_BITS-1:0]          p1_sample,
    input  logic [SAMPLE_BITS-1:0]          p0_sample,
    input  logic [SAMPLE_BITS-1:0]          q0_sample,
    input  logic [SAMPLE_BITS-1:0]          q1_sample,
    input  logic [cedf_pkg::BS_W-1:0]       edge_strength,
    input  logic [cedf_pkg::QP_W-1:0]       qp_left,
    input  logic [cedf_pkg::QP_W-1:0]       qp_right,
    input  logic                            neighbour_usable,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  cedf_pkg::cfg_idx_t              cfg_index,
    input  logic [cedf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic [SAMPLE_BITS-1:0]          p0_result,
    output logic [SAMPLE_BITS-1:0]          q0_result,
    output logic                            was_filtered
);
    import cedf_pkg::*;

    localparam int MAX_DEPTH = (SAMPLE_BITS < DEPTH_CAP) ? SAMPLE_BITS : DEPTH_CAP;
    localparam int CW = (SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W;
    localparam int DW = SAMPLE_BITS + 4;
    localparam int SW = SAMPLE_BITS + 2;
    localparam logic signed [DW-1:0] RND_D = DW'(4);
    localparam logic [SW-1:0] RND_S = SW'(2);

    // ---------------- configuration ----------------
    logic signed [OFS_W-1:0]   alpha_ofs_reg;
    logic signed [OFS_W-1:0]   beta_ofs_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    logic [MODE_W-1:0]         mode_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_ofs_reg <= '0;
            beta_ofs_reg  <= '0;
            depth_reg     <= DEPTH_W'(DEPTH_MIN);
            mode_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALPHA_OFFSET: alpha_ofs_reg <= $signed(cfg_data[OFS_W-1:0]);
                CFG_BETA_OFFSET:  beta_ofs_reg  <= $signed(cfg_data[OFS_W-1:0]);
                CFG_BIT_DEPTH:    depth_reg     <= cfg_data[DEPTH_W-1:0];
                CFG_DISABLE_MODE: mode_reg      <= cfg_data[MODE_W-1:0];
                default:          mode_reg      <= mode_reg;
            endcase
        end
    end

    logic [DEPTH_W-1:0]     depth_eff;
    logic [2:0]             scale_sh;
    logic [SAMPLE_BITS:0]   pel_full;
    logic [SAMPLE_BITS-1:0] pel_max;

    always_comb
    begin
        if (depth_reg < DEPTH_W'(DEPTH_MIN))
            depth_eff = DEPTH_W'(DEPTH_MIN);
        else if (depth_reg > DEPTH_W'(MAX_DEPTH))
            depth_eff = DEPTH_W'(MAX_DEPTH);
        else
            depth_eff = depth_reg;
        scale_sh = 3'(depth_eff - DEPTH_W'(DEPTH_MIN));
        pel_full = ((SAMPLE_BITS+1)'(1) << depth_eff) - (SAMPLE_BITS+1)'(1);
        pel_max  = pel_full[SAMPLE_BITS-1:0];
    end

    // ---------------- stage 1: QP average, table indexes ----------------
    logic                   accept;
    logic [QP_W:0]          qp_sum;
    logic [QP_W-1:0]        qp_avg;
    logic signed [QP_W+1:0] ia_raw, ib_raw;
    logic [QP_W-1:0]        ia_next, ib_next;
    logic [BS_W-1:0]        bs_next;
    logic                   en_next;

    assign accept = start && !busy;

    always_comb
    begin
        qp_sum  = (QP_W+1)'(qp_left) + (QP_W+1)'(qp_right) + (QP_W+1)'(1);
        qp_avg  = qp_sum[QP_W:1];
        ia_raw  = $signed({2'b00, qp_avg}) + (QP_W+2)'(alpha_ofs_reg);
        ib_raw  = $signed({2'b00, qp_avg}) + (QP_W+2)'(beta_ofs_reg);
        if (ia_raw < 0)
            ia_next = '0;
        else if (ia_raw > (QP_W+2)'(QP_MAX))
            ia_next = QP_W'(QP_MAX);
        else
            ia_next = ia_raw[QP_W-1:0];
        if (ib_raw < 0)
            ib_next = '0;
        else if (ib_raw > (QP_W+2)'(QP_MAX))
            ib_next = QP_W'(QP_MAX);
        else
            ib_next = ib_raw[QP_W-1:0];
        bs_next = (edge_strength > BS_STRONG) ? BS_STRONG : edge_strength;
        en_next = (neighbour_usable || mode_reg == MODE_FILTER_ALL)
                  && edge_strength != BS_NONE;
    end

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_p1_reg, s1_p0_reg, s1_q0_reg, s1_q1_reg;
    logic [QP_W-1:0]        s1_ia_reg, s1_ib_reg;
    logic [BS_W-1:0]        s1_bs_reg;
    logic                   s1_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_p1_reg <= p1_sample;
            s1_p0_reg <= p0_sample;
            s1_q0_reg <= q0_sample;
            s1_q1_reg <= q1_sample;
            s1_ia_reg <= ia_next;
            s1_ib_reg <= ib_next;
            s1_bs_reg <= bs_next;
            s1_en_reg <= en_next;
        end
    end

    // ---------------- stage 2: thresholds, tc, activity diffs ----------------
    logic [7:0]             tc0_raw;
    logic [TH_W-1:0]        alpha_next, beta_next;
    logic [TC_W-1:0]        tc_next;
    logic [SAMPLE_BITS-1:0] d_pq_next, d_q_next, d_p_next;

    always_comb
    begin
        case (s1_bs_reg)
            BS_ONE:  tc0_raw = TC0_BS1[s1_ia_reg];
            BS_TWO:  tc0_raw = TC0_BS2[s1_ia_reg];
            default: tc0_raw = TC0_BS3[s1_ia_reg];
        endcase
        alpha_next = TH_W'(ALPHA_TAB[s1_ia_reg]) << scale_sh;
        beta_next  = TH_W'(BETA_TAB[s1_ib_reg]) << scale_sh;
        tc_next    = (TC_W'(tc0_raw) << scale_sh) + TC_W'(1);
        d_pq_next  = (s1_q0_reg > s1_p0_reg) ? s1_q0_reg - s1_p0_reg : s1_p0_reg - s1_q0_reg;
        d_q_next   = (s1_q0_reg > s1_q1_reg) ? s1_q0_reg - s1_q1_reg : s1_q1_reg - s1_q0_reg;
        d_p_next   = (s1_p0_reg > s1_p1_reg) ? s1_p0_reg - s1_p1_reg : s1_p1_reg - s1_p0_reg;
    end

    logic                   s2_valid_reg;
    logic [SAMPLE_BITS-1:0] s2_p1_reg, s2_p0_reg, s2_q0_reg, s2_q1_reg;
    logic [SAMPLE_BITS-1:0] s2_dpq_reg, s2_dq_reg, s2_dp_reg;
    logic [TH_W-1:0]        s2_alpha_reg, s2_beta_reg;
    logic [TC_W-1:0]        s2_tc_reg;
    logic                   s2_strong_reg;
    logic                   s2_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_p1_reg     <= s1_p1_reg;
            s2_p0_reg     <= s1_p0_reg;
            s2_q0_reg     <= s1_q0_reg;
            s2_q1_reg     <= s1_q1_reg;
            s2_dpq_reg    <= d_pq_next;
            s2_dq_reg     <= d_q_next;
            s2_dp_reg     <= d_p_next;
            s2_alpha_reg  <= alpha_next;
            s2_beta_reg   <= beta_next;
            s2_tc_reg     <= tc_next;
            s2_strong_reg <= (s1_bs_reg == BS_STRONG);
            s2_en_reg     <= s1_en_reg;
        end
    end

    // ---------------- stage 3: decision, delta, strong taps ----------------
    logic                   pass_next;
    logic signed [DW-1:0]   sp1, sp0, sq0, sq1, raw, dlt, tc_s, delta_next;
    logic [SW-1:0]          sum_p, sum_q;

    always_comb
    begin
        pass_next = s2_en_reg
                    && CW'(s2_dpq_reg) < CW'(s2_alpha_reg)
                    && CW'(s2_dq_reg) < CW'(s2_beta_reg)
                    && CW'(s2_dp_reg) < CW'(s2_beta_reg);
        sp1  = $signed(DW'(s2_p1_reg));
        sp0  = $signed(DW'(s2_p0_reg));
        sq0  = $signed(DW'(s2_q0_reg));
        sq1  = $signed(DW'(s2_q1_reg));
        raw  = ((sq0 - sp0) <<< 2) + (sp1 - sq1) + RND_D;
        dlt  = raw >>> 3;   // floor division by 8
        tc_s = $signed(DW'(s2_tc_reg));
        if (dlt < -tc_s)
            delta_next = -tc_s;
        else if (dlt > tc_s)
            delta_next = tc_s;
        else
            delta_next = dlt;
        sum_p = {SW'(s2_p1_reg) << 1} + SW'(s2_p0_reg) + SW'(s2_q1_reg) + RND_S;
        sum_q = {SW'(s2_q1_reg) << 1} + SW'(s2_q0_reg) + SW'(s2_p1_reg) + RND_S;
    end

    logic                   s3_valid_reg;
    logic                   s3_pass_reg;
    logic                   s3_strong_reg;
    logic signed [DW-1:0]   s3_delta_reg;
    logic [SAMPLE_BITS-1:0] s3_p0_reg, s3_q0_reg, s3_sp0_reg, s3_sq0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_pass_reg   <= pass_next;
            s3_strong_reg <= s2_strong_reg;
            s3_delta_reg  <= delta_next;
            s3_p0_reg     <= s2_p0_reg;
            s3_q0_reg     <= s2_q0_reg;
            s3_sp0_reg    <= sum_p[SW-1:2];
            s3_sq0_reg    <= sum_q[SW-1:2];
        end
    end

    // ---------------- stage 4: clamp and select ----------------
    logic signed [DW-1:0]   np_sum, nq_sum, pel_s;
    logic [SAMPLE_BITS-1:0] np_clip, nq_clip, p0_next, q0_next;

    always_comb
    begin
        pel_s  = $signed(DW'(pel_max));
        np_sum = $signed(DW'(s3_p0_reg)) + s3_delta_reg;
        nq_sum = $signed(DW'(s3_q0_reg)) - s3_delta_reg;
        if (np_sum < 0)
            np_clip = '0;
        else if (np_sum > pel_s)
            np_clip = pel_max;
        else
            np_clip = np_sum[SAMPLE_BITS-1:0];
        if (nq_sum < 0)
            nq_clip = '0;
        else if (nq_sum > pel_s)
            nq_clip = pel_max;
        else
            nq_clip = nq_sum[SAMPLE_BITS-1:0];
        if (!s3_pass_reg)
        begin
            p0_next = s3_p0_reg;
            q0_next = s3_q0_reg;
        end
        else if (s3_strong_reg)
        begin
            p0_next = s3_sp0_reg;
            q0_next = s3_sq0_reg;
        end
        else
        begin
            p0_next = np_clip;
            q0_next = nq_clip;
        end
    end

    logic                   done_reg;
    logic [SAMPLE_BITS-1:0] p0_res_reg, q0_res_reg;
    logic                   filt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            p0_res_reg <= p0_next;
            q0_res_reg <= q0_next;
            filt_reg   <= s3_pass_reg;
        end
    end

    assign done         = done_reg;
    assign p0_result    = p0_res_reg;
    assign q0_result    = q0_res_reg;
    assign was_filtered = filt_reg;

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("row did not come out after four cycles");

    a_unfiltered_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        done && !was_filtered |->
            p0_result == $past(p0_sample, 4) && q0_result == $past(q0_sample, 4))
        else $error("unfiltered row changed its samples");

    a_no_filter_bs0: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_filtered |-> $past(edge_strength, 4) != BS_NONE)
        else $error("row filtered with zero strength");

endmodule
